FILE: rtl/core/tbpq_pkg.sv
`timescale 1ns / 1ps

package tbpq_pkg;

   localparam int COORD_W   = 12;
   localparam int TIME_W    = 32;
   localparam int CFG_W     = 16;
   localparam int KIND_W    = 2;
   localparam int INDEX_W   = 3;
   localparam int OPCODE_W  = 2;
   localparam int CSR_IDX_W = 2;
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 8;

   // at most this many results per sample
   localparam int RESULTS_MAX = 8;
   localparam int NRES_W      = 4;

   localparam logic [OPCODE_W-1:0] OP_TOUCH  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

   localparam logic [KIND_W-1:0] KIND_SHORT  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MEDIUM = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LONG   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEDIUM  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE = 2'd3;

   localparam logic [CFG_W-1:0] REPEAT_RESET  = 16'd200;
   localparam logic [CFG_W-1:0] MEDIUM_RESET  = 16'd1500;
   localparam logic [CFG_W-1:0] LONG_RESET    = 16'd3000;
   localparam logic [CFG_W-1:0] RELEASE_RESET = 16'd40;

   typedef enum logic [1:0] {
      CMD_TOUCH,
      CMD_APPEND,
      CMD_CLEAR,
      CMD_NONE
   } cmd_type;

   typedef struct packed {
      cmd_type              cmd;
      logic                 touched;
      logic [COORD_W-1:0]   touch_x;
      logic [COORD_W-1:0]   touch_y;
      logic [TIME_W-1:0]    now_ms;
      logic [COORD_W-1:0]   box_left;
      logic [COORD_W-1:0]   box_top;
      logic [COORD_W-1:0]   box_width;
      logic [COORD_W-1:0]   box_height;
   } item_type;

   typedef struct packed {
      logic [CFG_W-1:0] repeat_interval_ms;
      logic [CFG_W-1:0] medium_hold_ms;
      logic [CFG_W-1:0] long_hold_ms;
      logic [CFG_W-1:0] release_timeout_ms;
   } cfg_type;

endpackage

FILE: rtl/core/tbpq_front.sv
`timescale 1ns / 1ps

module tbpq_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tbpq_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [tbpq_pkg::OPCODE_W-1:0]       req_tuser,
   output logic                                q_valid,
   output tbpq_pkg::item_type                  q_item,
   input  logic                                q_pop
);
   import tbpq_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] fill_ff;
   item_type   item_in;
   logic       push;

   always_comb begin
      item_in.touched    = req_tdata[0];
      item_in.touch_x    = req_tdata[12:1];
      item_in.touch_y    = req_tdata[24:13];
      item_in.now_ms     = req_tdata[56:25];
      item_in.box_left   = req_tdata[68:57];
      item_in.box_top    = req_tdata[80:69];
      item_in.box_width  = req_tdata[92:81];
      item_in.box_height = req_tdata[104:93];
      case (req_tuser)
         OP_TOUCH:  item_in.cmd = CMD_TOUCH;
         OP_APPEND: item_in.cmd = CMD_APPEND;
         OP_CLEAR:  item_in.cmd = CMD_CLEAR;
         default:   item_in.cmd = CMD_NONE;
      endcase
   end

   assign req_tready = (fill_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (fill_ff != 2'd0);
   assign q_item     = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            slot_ff[wr_ptr_ff] <= item_in;
            wr_ptr_ff          <= ~wr_ptr_ff;
         end
         if (q_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !q_pop) begin
            fill_ff <= fill_ff + 2'd1;
         end else if (!push && q_pop) begin
            fill_ff <= fill_ff - 2'd1;
         end
      end
   end

endmodule

FILE: rtl/core/tbpq_back.sv
`timescale 1ns / 1ps

module tbpq_back #(
   parameter int MAX_BTNS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tbpq_pkg::cfg_type               cfg,
   input  logic                            q_valid,
   input  tbpq_pkg::item_type              q_item,
   output logic                            q_pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tbpq_pkg::INDEX_W-1:0]    rsp_index,
   output logic [tbpq_pkg::KIND_W-1:0]     rsp_kind,
   output logic                            rsp_tlast
);
   import tbpq_pkg::*;

   localparam int CNT_W = $clog2(MAX_BTNS + 1);
   localparam int IDX_W = (MAX_BTNS > 1) ? $clog2(MAX_BTNS) : 1;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BTNS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] width;
      logic [COORD_W-1:0] height;
   } box_type;

   state_type           state_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    idx_ff;
   logic [NRES_W-1:0]   nres_ff;
   item_type            smp_ff;
   box_type             box_ff        [MAX_BTNS];
   logic [TIME_W-1:0]   last_fire_ff  [MAX_BTNS];
   logic [TIME_W-1:0]   hold_start_ff [MAX_BTNS];
   logic [TIME_W-1:0]   last_seen_ff  [MAX_BTNS];
   logic [MAX_BTNS-1:0] held_ff;
   logic                pend_valid_ff;
   logic [INDEX_W-1:0]  pend_index_ff;
   logic [KIND_W-1:0]   pend_kind_ff;
   logic                rsp_valid_ff;
   logic [INDEX_W-1:0]  rsp_index_ff;
   logic [KIND_W-1:0]   rsp_kind_ff;
   logic                rsp_last_ff;

   logic [IDX_W-1:0]    sel;
   box_type             box;
   logic                held;
   logic                in_box;
   logic                hit;
   logic [TIME_W-1:0]   since;
   logic [TIME_W-1:0]   hold_time;
   logic [TIME_W-1:0]   absent;
   logic                due;
   logic                fire;
   logic [KIND_W-1:0]   kind;
   logic                emit;
   logic                out_free;
   logic                step;
   logic                scan_end;
   logic                rsp_load;

   assign sel       = idx_ff[IDX_W-1:0];
   assign box       = box_ff[sel];
   assign held      = held_ff[sel];
   assign since     = smp_ff.now_ms - last_fire_ff[sel];
   assign hold_time = smp_ff.now_ms - hold_start_ff[sel];
   assign absent    = smp_ff.now_ms - last_seen_ff[sel];
   assign due       = since > TIME_W'(cfg.repeat_interval_ms);
   assign scan_end  = (idx_ff == count_ff);

   always_comb begin
      in_box = ({1'b0, smp_ff.touch_x} >= {1'b0, box.left})
            && ({1'b0, smp_ff.touch_x} <= ({1'b0, box.left} + {1'b0, box.width}))
            && ({1'b0, smp_ff.touch_y} >= {1'b0, box.top})
            && ({1'b0, smp_ff.touch_y} <= ({1'b0, box.top} + {1'b0, box.height}));
      hit  = smp_ff.touched && in_box;
      fire = 1'b0;
      kind = KIND_SHORT;
      if (hit && due) begin
         if (!held) begin
            fire = 1'b1;
         end else if (hold_time > TIME_W'(cfg.long_hold_ms)) begin
            fire = 1'b1;
            kind = KIND_LONG;
         end else if (hold_time > TIME_W'(cfg.medium_hold_ms)) begin
            fire = 1'b1;
            kind = KIND_MEDIUM;
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign emit     = fire && (nres_ff < NRES_W'(RESULTS_MAX));
   // the held result goes out when a newer one replaces it, or in the flush at the end of the scan
   assign step     = !(emit && pend_valid_ff && !out_free);
   assign q_pop    = (state_ff == ST_IDLE) && q_valid;
   assign rsp_load = ((state_ff == ST_SCAN) && !scan_end && step && emit && pend_valid_ff)
                  || ((state_ff == ST_FLUSH) && pend_valid_ff && out_free);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_index  = rsp_index_ff;
   assign rsp_kind   = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         idx_ff        <= '0;
         nres_ff       <= '0;
         held_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < MAX_BTNS; i++) begin
            hold_start_ff[i] <= '0;
         end
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_index_ff <= pend_index_ff;
            rsp_kind_ff  <= pend_kind_ff;
            rsp_last_ff  <= (state_ff == ST_FLUSH);
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  case (q_item.cmd)
                     CMD_APPEND: begin
                        if (count_ff < CNT_MAX) begin
                           box_ff[count_ff[IDX_W-1:0]] <= '{q_item.box_left,
                              q_item.box_top, q_item.box_width, q_item.box_height};
                           last_fire_ff[count_ff[IDX_W-1:0]]  <= q_item.now_ms;
                           last_seen_ff[count_ff[IDX_W-1:0]]  <= '0;
                           hold_start_ff[count_ff[IDX_W-1:0]] <= '0;
                           held_ff[count_ff[IDX_W-1:0]]       <= 1'b0;
                           count_ff <= count_ff + CNT_W'(1);
                        end
                     end
                     CMD_CLEAR: begin
                        count_ff <= '0;
                     end
                     CMD_TOUCH: begin
                        smp_ff        <= q_item;
                        idx_ff        <= '0;
                        nres_ff       <= '0;
                        pend_valid_ff <= 1'b0;
                        state_ff      <= ST_SCAN;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               if (scan_end) begin
                  state_ff <= ST_FLUSH;
               end else if (step) begin
                  if (hit) begin
                     last_seen_ff[sel] <= smp_ff.now_ms;
                     if (due) begin
                        last_fire_ff[sel] <= smp_ff.now_ms;
                        if (!held) begin
                           held_ff[sel]       <= 1'b1;
                           hold_start_ff[sel] <= smp_ff.now_ms;
                        end
                     end
                  end else if (held && (absent > TIME_W'(cfg.release_timeout_ms))) begin
                     held_ff[sel] <= 1'b0;
                  end
                  if (emit) begin
                     pend_valid_ff <= 1'b1;
                     pend_index_ff <= INDEX_W'(idx_ff);
                     pend_kind_ff  <= kind;
                     nres_ff       <= nres_ff + NRES_W'(1);
                  end
                  idx_ff <= idx_ff + CNT_W'(1);
               end
            end
            ST_FLUSH: begin
               if (!pend_valid_ff) begin
                  state_ff <= ST_IDLE;
               end else if (out_free) begin
                  pend_valid_ff <= 1'b0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: rtl/core/touch_button_press_qualifier.sv
`timescale 1ns / 1ps

// Touch button press qualifier. Holds a table of up to MAX_BTNS rectangular
// buttons built by append and clear items, and hit-tests each touch sample
// against every entry in table order, reporting short presses and medium or
// long hold repeats, one result transfer per fire, the last one of a sample
// flagged by rsp_tlast (at most eight results per sample). Input items pass
// through a two-entry queue; an append, clear or unknown item is handled in
// the back end's idle state, while a touch sample passes through dispatch,
// one scan step per table entry in the scan sequencer, a scan-end step and a
// final-result step, held longer only while rsp_tready holds off a result.
// Timing registers are written over the csr channel, which is always ready,
// and should be changed only while the block is idle.
module touch_button_press_qualifier #(
   parameter int MAX_BTNS = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // touched, touch_x, touch_y, now_ms, box_left, box_top, box_width,
   // box_height, zero fill
   input  logic [111:0]  req_tdata,
   // opcode
   input  logic [1:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // button_index, zero fill
   output logic [7:0]    rsp_tdata,
   // press_kind
   output logic [1:0]    rsp_tuser,
   output logic          rsp_tlast,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_data
);
   import tbpq_pkg::*;

   cfg_type            cfg_ff;
   logic               q_valid;
   item_type           q_item;
   logic               q_pop;
   logic [INDEX_W-1:0] rsp_index;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.repeat_interval_ms <= REPEAT_RESET;
         cfg_ff.medium_hold_ms     <= MEDIUM_RESET;
         cfg_ff.long_hold_ms       <= LONG_RESET;
         cfg_ff.release_timeout_ms <= RELEASE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_REPEAT:  cfg_ff.repeat_interval_ms <= csr_data;
            CSR_MEDIUM:  cfg_ff.medium_hold_ms     <= csr_data;
            CSR_LONG:    cfg_ff.long_hold_ms       <= csr_data;
            CSR_RELEASE: cfg_ff.release_timeout_ms <= csr_data;
            default: begin
            end
         endcase
      end
   end

   tbpq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   tbpq_back #(
      .MAX_BTNS (MAX_BTNS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_index  (rsp_index),
      .rsp_kind   (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   assign rsp_tdata = {5'b0, rsp_index};

`ifndef SYNTHESIS
   a_cfg_reset: assert property (@(posedge clock)
      reset |=> (cfg_ff.repeat_interval_ms == REPEAT_RESET)
             && (cfg_ff.medium_hold_ms == MEDIUM_RESET)
             && (cfg_ff.long_hold_ms == LONG_RESET)
             && (cfg_ff.release_timeout_ms == RELEASE_RESET))
      else $error("timing registers not at reset values");

   a_csr_repeat: assert property (@(posedge clock) disable iff (reset)
      csr_valid && (csr_index == CSR_REPEAT)
         |=> cfg_ff.repeat_interval_ms == $past(csr_data))
      else $error("repeat interval write lost");

   a_csr_release: assert property (@(posedge clock) disable iff (reset)
      csr_valid && (csr_index == CSR_RELEASE)
         |=> cfg_ff.release_timeout_ms == $past(csr_data))
      else $error("release timeout write lost");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == KIND_SHORT) || (rsp_tuser == KIND_MEDIUM)
                  || (rsp_tuser == KIND_LONG))
      else $error("illegal press kind on result");
`endif

endmodule
